// ===== rtl/unsigned_radix_text_formatter_macros.svh =====
// Assertion macros shared by the formatter RTL.
`ifndef UNSIGNED_RADIX_TEXT_FORMATTER_MACROS_SVH
`define UNSIGNED_RADIX_TEXT_FORMATTER_MACROS_SVH
`ifndef ASSERT_OFF
`define URTF_ASSERT_IMP(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("urtf assertion failed");
`define URTF_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("urtf assertion failed");
`else
`define URTF_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define URTF_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ===== rtl/urtf_pkg.sv =====
// Types, constants and helper functions of the unsigned radix text formatter.
package urtf_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned CntW = 6;
  localparam int unsigned BcdW = 80;
  localparam int unsigned DecDigits = 20;
  localparam int unsigned TextW = 64;
  localparam int unsigned CountW = 4;
  localparam int unsigned LenW = 8;
  localparam int unsigned PosW = 9;
  localparam int unsigned NdigW = 7;
  localparam int unsigned CharsPerResultDef = 8;

  localparam logic [7:0] AsciiSpace = 8'h20;
  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiComma = 8'h2C;
  localparam logic [7:0] AsciiUnder = 8'h5F;
  localparam logic [7:0] AsciiLowA = 8'h61;
  localparam logic [7:0] AsciiUpA = 8'h41;
  localparam logic [7:0] AsciiLowB = 8'h62;
  localparam logic [7:0] AsciiUpB = 8'h42;
  localparam logic [7:0] AsciiLowX = 8'h78;
  localparam logic [7:0] AsciiUpX = 8'h58;

  typedef enum logic [1:0] {
    BaseBin = 2'd0,
    BaseOct = 2'd1,
    BaseDec = 2'd2,
    BaseHex = 2'd3
  } base_e;

  typedef enum logic [1:0] {
    Width8 = 2'd0,
    Width16 = 2'd1,
    Width32 = 2'd2,
    Width64 = 2'd3
  } width_e;

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StConv  = 8'b0000_0010,
    StScan  = 8'b0000_0100,
    StSizeA = 8'b0000_1000,
    StSizeB = 8'b0001_0000,
    StSizeC = 8'b0010_0000,
    StSizeD = 8'b0100_0000,
    StEmit  = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [1:0]        base_select;
    logic [1:0]        width_select;
    logic              upper_case;
    logic              alt_prefix;
    logic              group_digits;
    logic              zero_pad;
    logic              left_align;
    logic              has_precision;
    logic [6:0]        precision;
    logic [7:0]        min_width;
  } in_t;

  typedef struct packed {
    logic [TextW-1:0]  text_bytes;
    logic [CountW-1:0] byte_count;
    logic              last_chunk;
  } out_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic scan;
    logic size_a;
    logic size_b;
    logic size_c;
    logic size_d;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic emit_last;
  } status_t;

  // Quotient by the group span (gap plus one) for values below 512.
  function automatic logic [8:0] div_span(logic [8:0] x, base_e b);
    logic [20:0] p;
    p = '0;
    case (b)
      BaseBin: p = 21'(x) * 21'd456;
      BaseDec: p = 21'(x) << 10;
      BaseOct, BaseHex: p = 21'(x) * 21'd820;
      default: p = '0;
    endcase
    return p[20:12];
  endfunction

  // Quotient by the group gap for values below 256.
  function automatic logic [7:0] div_gap(logic [7:0] x, base_e b);
    logic [19:0] p;
    p = '0;
    case (b)
      BaseBin: p = 20'(x) << 9;
      BaseDec: p = 20'(x) * 20'd1366;
      BaseOct, BaseHex: p = 20'(x) << 10;
      default: p = '0;
    endcase
    return p[19:12];
  endfunction

  function automatic logic [3:0] gap_of(base_e b);
    logic [3:0] g;
    case (b)
      BaseBin: g = 4'd8;
      BaseDec: g = 4'd3;
      BaseOct, BaseHex: g = 4'd4;
      default: g = 4'd4;
    endcase
    return g;
  endfunction

  function automatic logic [1:0] prefix_len(base_e b, logic alt);
    logic [1:0] l;
    case (b)
      BaseBin, BaseHex: l = 2'd2;
      BaseOct: l = 2'd1;
      BaseDec: l = 2'd0;
      default: l = 2'd0;
    endcase
    return alt ? l : 2'd0;
  endfunction

  function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = AsciiZero + 8'(d);
    end else begin
      c = (upper ? AsciiUpA : AsciiLowA) + 8'(d) - 8'd10;
    end
    return c;
  endfunction

endpackage

// ===== rtl/urtf_ctrl.sv =====
// Sequencing state machine of the formatter.
module urtf_ctrl
  import urtf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = StConv;
        end
      end
      StConv: begin
        cmd_o.conv = 1'b1;
        if (status_i.cnt_last) state_d = StScan;
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (status_i.cnt_last) state_d = StSizeA;
      end
      StSizeA: begin
        cmd_o.size_a = 1'b1;
        state_d = StSizeB;
      end
      StSizeB: begin
        cmd_o.size_b = 1'b1;
        state_d = StSizeC;
      end
      StSizeC: begin
        cmd_o.size_c = 1'b1;
        state_d = StSizeD;
      end
      StSizeD: begin
        cmd_o.size_d = 1'b1;
        state_d = StEmit;
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        if (status_i.emit_last) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/urtf_datapath.sv =====
// Conversion, sizing and character assembly datapath of the formatter.
module urtf_datapath
  import urtf_pkg::*;
#(
  parameter int unsigned CHARS_PER_RESULT = CharsPerResultDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  in_t     item_i,
  input  cmd_t    cmd_i,
  output status_t status_o,
  output logic    result_valid_o,
  output out_t    result_o
);

  localparam int unsigned SlotW = (CHARS_PER_RESULT > 1) ? $clog2(CHARS_PER_RESULT) : 1;
  localparam int unsigned BufW = 8 * CHARS_PER_RESULT;

  logic [ValueW-1:0] val_q, val_d, sh_q, sh_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  base_e             base_q, base_d;
  logic              upper_q, upper_d, alt_q, alt_d, group_q, group_d;
  logic              zpad_q, zpad_d, left_q, left_d, hasp_q, hasp_d, zp_q, zp_d;
  logic [6:0]        prec_q, prec_d;
  logic [7:0]        minw_q, minw_d, tgt_q, tgt_d, q1_q, q1_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [NdigW-1:0]  ndig_q, ndig_d;
  logic [LenW-1:0]   len_q, len_d, idx_q, idx_d;
  logic [3:0]        r_q, r_d;
  logic [PosW-1:0]   blen_q, blen_d, lead_q, lead_d, pre_end_q, pre_end_d;
  logic [PosW-1:0]   body_end_q, body_end_d, n_q, n_d, pos_q, pos_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [BufW-1:0]   buf_q, buf_d;
  out_t              res_q, res_d;
  logic              res_valid_q, res_valid_d;

  function automatic logic [3:0] digit_at(logic [LenW-1:0] idx, base_e b,
                                          logic [ValueW-1:0] v, logic [BcdW-1:0] bcd);
    logic [ValueW+1:0] v66;
    logic [6:0]        opos;
    logic [3:0]        d;
    v66 = {2'b00, v};
    opos = {2'b00, idx[4:0]} + {1'b0, idx[4:0], 1'b0};
    d = 4'd0;
    case (b)
      BaseBin: if (idx < 8'd64) d = {3'b000, v[idx[5:0]]};
      BaseOct: if (idx < 8'd22) d = {1'b0, v66[opos +: 3]};
      BaseDec: if (idx < 8'(DecDigits)) d = bcd[{idx[4:0], 2'b00} +: 4];
      BaseHex: if (idx < 8'd16) d = v[{idx[3:0], 2'b00} +: 4];
      default: d = 4'd0;
    endcase
    return d;
  endfunction

  logic [BcdW-1:0]  bcd_adj;
  logic [6:0]       prec_eff;
  logic [1:0]       plen;
  logic [PosW-1:0]  plen9, minw9, used, pad, q2, span_prod;
  logic [3:0]       gap;
  logic [7:0]       fill, seps, ch;
  logic             is_sep, in_body, chunk_end, last_char;
  logic [BufW-1:0]  nbuf;

  assign gap = gap_of(base_q);
  assign plen = prefix_len(base_q, alt_q);
  assign plen9 = {7'd0, plen};
  assign minw9 = {1'b0, minw_q};
  assign prec_eff = hasp_q ? prec_q : 7'd1;
  assign last_char = (n_q == '0) || (pos_q == n_q - 9'd1);

  always_comb begin
    for (int i = 0; i < DecDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                    : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    val_d = val_q;
    sh_d = sh_q;
    bcd_d = bcd_q;
    base_d = base_q;
    upper_d = upper_q;
    alt_d = alt_q;
    group_d = group_q;
    zpad_d = zpad_q;
    left_d = left_q;
    hasp_d = hasp_q;
    prec_d = prec_q;
    minw_d = minw_q;
    zp_d = zp_q;
    tgt_d = tgt_q;
    q1_d = q1_q;
    cnt_d = cnt_q;
    ndig_d = ndig_q;
    len_d = len_q;
    idx_d = idx_q;
    r_d = r_q;
    blen_d = blen_q;
    lead_d = lead_q;
    pre_end_d = pre_end_q;
    body_end_d = body_end_q;
    n_d = n_q;
    pos_d = pos_q;
    slot_d = slot_q;
    buf_d = buf_q;
    res_d = res_q;
    res_valid_d = 1'b0;
    fill = '0;
    seps = '0;
    q2 = '0;
    span_prod = '0;
    used = '0;
    pad = '0;
    ch = AsciiSpace;
    is_sep = 1'b0;
    in_body = 1'b0;
    chunk_end = 1'b0;
    nbuf = buf_q;

    if (cmd_i.load) begin
      case (width_e'(item_i.width_select))
        Width8:  val_d = {56'd0, item_i.value[7:0]};
        Width16: val_d = {48'd0, item_i.value[15:0]};
        Width32: val_d = {32'd0, item_i.value[31:0]};
        Width64: val_d = item_i.value;
        default: val_d = item_i.value;
      endcase
      sh_d = val_d;
      bcd_d = '0;
      base_d = base_e'(item_i.base_select);
      upper_d = item_i.upper_case;
      alt_d = item_i.alt_prefix;
      group_d = item_i.group_digits;
      zpad_d = item_i.zero_pad;
      left_d = item_i.left_align;
      hasp_d = item_i.has_precision;
      prec_d = item_i.precision;
      minw_d = item_i.min_width;
      cnt_d = '0;
      ndig_d = '0;
    end

    if (cmd_i.conv) begin
      bcd_d = {bcd_adj[BcdW-2:0], sh_q[ValueW-1]};
      sh_d = {sh_q[ValueW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
    end

    if (cmd_i.scan) begin
      if (digit_at({2'b00, cnt_q}, base_q, val_q, bcd_q) != 4'd0) begin
        ndig_d = {1'b0, cnt_q} + 7'd1;
      end
      cnt_d = cnt_q + 1'b1;
    end

    if (cmd_i.size_a) begin
      len_d = (ndig_q > prec_eff) ? {1'b0, ndig_q} : {1'b0, prec_eff};
      tgt_d = (minw_q > {6'd0, plen}) ? minw_q - {6'd0, plen} : 8'd0;
      zp_d = zpad_q && !left_q && !hasp_q && (minw_q > {6'd0, plen});
      q1_d = 8'(div_span({1'b0, tgt_d}, base_q));
    end

    if (cmd_i.size_b) begin
      fill = group_q ? tgt_q - q1_q : tgt_q;
      if (zp_q && (fill > len_q)) len_d = fill;
    end

    if (cmd_i.size_c) begin
      seps = (group_q && (len_q != '0)) ? div_gap(len_q - 8'd1, base_q) : 8'd0;
      blen_d = {1'b0, len_q} + {1'b0, seps};
      idx_d = len_q - 8'd1;
    end

    if (cmd_i.size_d) begin
      q2 = div_span(blen_q, base_q);
      span_prod = 9'(q2 * ({1'b0, gap} + 5'd1));
      r_d = 4'(blen_q - span_prod);
      used = plen9 + blen_q;
      pad = (minw9 > used) ? minw9 - used : '0;
      lead_d = left_q ? '0 : pad;
      pre_end_d = lead_d + plen9;
      body_end_d = pre_end_d + blen_q;
      n_d = used + pad;
      pos_d = '0;
      slot_d = '0;
      buf_d = '0;
    end

    if (cmd_i.emit) begin
      if (pos_q < lead_q) begin
        ch = AsciiSpace;
      end else if (pos_q < pre_end_q) begin
        if (pos_q == lead_q) begin
          ch = AsciiZero;
        end else if (base_q == BaseBin) begin
          ch = upper_q ? AsciiUpB : AsciiLowB;
        end else begin
          ch = upper_q ? AsciiUpX : AsciiLowX;
        end
      end else if (pos_q < body_end_q) begin
        in_body = 1'b1;
        is_sep = group_q && (r_q == 4'd0);
        if (is_sep) begin
          ch = (base_q == BaseDec) ? AsciiComma : AsciiUnder;
        end else begin
          ch = digit_char(digit_at(idx_q, base_q, val_q, bcd_q), upper_q);
        end
      end else begin
        ch = AsciiSpace;
      end

      if (in_body) begin
        r_d = (r_q == 4'd0) ? gap : r_q - 4'd1;
        if (!is_sep) idx_d = idx_q - 8'd1;
      end

      nbuf[{slot_q, 3'b000} +: 8] = ch;
      chunk_end = (slot_q == SlotW'(CHARS_PER_RESULT - 1)) || last_char;
      pos_d = pos_q + 9'd1;

      if (n_q == '0) begin
        res_valid_d = 1'b1;
        res_d.text_bytes = '0;
        res_d.byte_count = '0;
        res_d.last_chunk = 1'b1;
      end else if (chunk_end) begin
        res_valid_d = 1'b1;
        res_d.text_bytes = TextW'(nbuf);
        res_d.byte_count = CountW'(slot_q) + CountW'(1);
        res_d.last_chunk = last_char;
        buf_d = '0;
        slot_d = '0;
      end else begin
        buf_d = nbuf;
        slot_d = slot_q + 1'b1;
      end
    end
  end

  assign status_o.cnt_last = &cnt_q;
  assign status_o.emit_last = last_char;
  assign result_valid_o = res_valid_q;
  assign result_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      res_valid_q <= res_valid_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    sh_q <= sh_d;
    bcd_q <= bcd_d;
    base_q <= base_d;
    upper_q <= upper_d;
    alt_q <= alt_d;
    group_q <= group_d;
    zpad_q <= zpad_d;
    left_q <= left_d;
    hasp_q <= hasp_d;
    prec_q <= prec_d;
    minw_q <= minw_d;
    zp_q <= zp_d;
    tgt_q <= tgt_d;
    q1_q <= q1_d;
    ndig_q <= ndig_d;
    len_q <= len_d;
    idx_q <= idx_d;
    r_q <= r_d;
    blen_q <= blen_d;
    lead_q <= lead_d;
    pre_end_q <= pre_end_d;
    body_end_q <= body_end_d;
    n_q <= n_d;
    pos_q <= pos_d;
    slot_q <= slot_d;
    buf_q <= buf_d;
    res_q <= res_d;
  end

endmodule

// ===== rtl/unsigned_radix_text_formatter.sv =====
// Top level of the unsigned radix text formatter.
//
//   Channel   Handshake              Payload
//   input     start high, busy low   item_i   (in_t)
//   result    result_valid_o strobe  result_o (out_t)
//
// An item keeps the block busy through shift-and-add-three decimal conversion, a digit
// scan over 64 digit positions for the digit count, four sizing states (StSizeA to
// StSizeD) and the emission of one character per cycle.
// A result is strobed in the cycle after its last character has been placed.
// Reset clears the sequencer and the result strobe; the receiver cannot stall a transfer.
`include "unsigned_radix_text_formatter_macros.svh"
module unsigned_radix_text_formatter
  import urtf_pkg::*;
#(
  parameter int unsigned CHARS_PER_RESULT = CharsPerResultDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  item_i,
  output logic result_valid_o,
  output out_t result_o
);

  cmd_t    cmd;
  status_t status;

  urtf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  urtf_datapath #(
    .CHARS_PER_RESULT (CHARS_PER_RESULT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  `URTF_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
  `URTF_ASSERT_IMP(a_count_max, clk_i, rst_ni, result_valid_o, result_o.byte_count <= CountW'(CHARS_PER_RESULT))
  `URTF_ASSERT_IMP(a_full_chunk, clk_i, rst_ni, result_valid_o && !result_o.last_chunk, result_o.byte_count == CountW'(CHARS_PER_RESULT))
  `URTF_ASSERT_NEXT(a_last_single, clk_i, rst_ni, result_valid_o && result_o.last_chunk, !result_valid_o)

endmodule

// ===== sim/unsigned_radix_text_formatter_tb.sv =====
// Self-checking testbench of the unsigned radix text formatter, with a built-in text predictor.
`timescale 1ns / 100ps
module unsigned_radix_text_formatter_tb;
  import urtf_pkg::*;

  localparam int unsigned ChunkChars = 8;
  localparam longint unsigned CycleLimit = 400000;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  in_t item_i;
  logic result_valid_o;
  out_t result_o;

  in_t pending_items[$];
  out_t expected_chunks[$];
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned chunks_seen;
  int unsigned send_idle_pct;
  longint unsigned cycle_count;
  bit stimulus_done;

  unsigned_radix_text_formatter #(
    .CHARS_PER_RESULT(ChunkChars)
  ) i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .item_i(item_i),
    .result_valid_o(result_valid_o),
    .result_o(result_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Builds the text of one item and splits it into chunks.
  function automatic void format_number(input in_t it);
    logic [7:0] body[$];
    logic [7:0] text[$];
    logic [63:0] v;
    logic [63:0] t;
    logic [63:0] bytes;
    int unsigned radix, gap, plen, off, ndig, prec, minw, len, total, pad;
    int unsigned target, fill, chunks, cnt;
    logic [7:0] sep;
    string digits;
    out_t r;
    digits = "0123456789abcdef0123456789ABCDEF";
    v = it.value;
    case (width_e'(it.width_select))
      Width8: v = v & 64'hFF;
      Width16: v = v & 64'hFFFF;
      Width32: v = v & 64'hFFFF_FFFF;
      default: ;
    endcase
    case (base_e'(it.base_select))
      BaseBin: begin radix = 2; gap = 8; plen = 2; end
      BaseOct: begin radix = 8; gap = 4; plen = 1; end
      BaseDec: begin radix = 10; gap = 3; plen = 0; end
      default: begin radix = 16; gap = 4; plen = 2; end
    endcase
    sep = (base_e'(it.base_select) == BaseDec) ? AsciiComma : AsciiUnder;
    if (!it.alt_prefix) plen = 0;
    off = it.upper_case ? 16 : 0;
    prec = it.has_precision ? it.precision : 1;
    minw = it.min_width;
    ndig = 0;
    for (t = v; t != 0; t = t / radix) ndig++;
    len = (ndig > prec) ? ndig : prec;
    if (it.zero_pad && !it.left_align && !it.has_precision && minw > plen) begin
      target = minw - plen;
      fill = it.group_digits ? target - target / (gap + 1) : target;
      if (fill > len) len = fill;
    end
    total = len + ((it.group_digits && len > 0) ? (len - 1) / gap : 0);
    for (int unsigned p = 1; p <= total; p++) begin
      if (it.group_digits && (p % (gap + 1)) == 0) begin
        body.push_front(sep);
      end else begin
        body.push_front(digits[(v % radix) + off]);
        v = v / radix;
      end
    end
    pad = (minw > plen + total) ? minw - plen - total : 0;
    if (!it.left_align) repeat (pad) text.push_back(AsciiSpace);
    if (plen > 0) text.push_back(AsciiZero);
    if (plen == 2) begin
      if (base_e'(it.base_select) == BaseBin) text.push_back(it.upper_case ? AsciiUpB : AsciiLowB);
      else text.push_back(it.upper_case ? AsciiUpX : AsciiLowX);
    end
    foreach (body[i]) text.push_back(body[i]);
    if (it.left_align) repeat (pad) text.push_back(AsciiSpace);
    chunks = (text.size() + ChunkChars - 1) / ChunkChars;
    if (chunks == 0) chunks = 1;
    for (int unsigned k = 0; k < chunks; k++) begin
      cnt = (k * ChunkChars >= text.size()) ? 0 : text.size() - k * ChunkChars;
      if (cnt > ChunkChars) cnt = ChunkChars;
      bytes = '0;
      for (int unsigned i = 0; i < cnt; i++) bytes[8*i +: 8] = text[k * ChunkChars + i];
      r.text_bytes = bytes;
      r.byte_count = cnt[CountW-1:0];
      r.last_chunk = (k + 1 == chunks);
      expected_chunks.push_back(r);
    end
  endfunction

  function automatic in_t random_item();
    in_t it;
    it.value = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: it.value = it.value >> $urandom_range(0, 63);
      1: it.value = 64'(1) << $urandom_range(0, 63);
      default: ;
    endcase
    it.base_select = 2'($urandom_range(0, 3));
    it.width_select = 2'($urandom_range(0, 3));
    {it.upper_case, it.alt_prefix, it.group_digits, it.zero_pad, it.left_align} =
      5'($urandom);
    it.has_precision = 1'($urandom);
    it.precision = ($urandom_range(0, 5) == 0) ? 7'($urandom) : 7'($urandom_range(0, 24));
    it.min_width = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
    return it;
  endfunction

  function automatic in_t plain_item(input logic [63:0] v, input base_e b);
    in_t it;
    it = '0;
    it.value = v;
    it.base_select = b;
    it.width_select = Width64;
    return it;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      item_i <= '0;
    end else begin
      if (start && !busy) begin
        format_number(item_i);
        items_sent++;
      end
      if (!start || !busy) begin
        if (pending_items.size() == 0 || $urandom_range(0, 99) < send_idle_pct) begin
          start <= 1'b0;
        end else begin
          item_i <= pending_items.pop_front();
          start <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && result_valid_o) begin
      chunks_seen++;
      if (expected_chunks.size() == 0) begin
        report_mismatch("chunk arrived with none expected");
      end else begin
        out_t e;
        e = expected_chunks.pop_front();
        if (result_o.text_bytes !== e.text_bytes)
          report_mismatch($sformatf("text_bytes %h, expected %h", result_o.text_bytes,
                                    e.text_bytes));
        if (result_o.byte_count !== e.byte_count)
          report_mismatch($sformatf("byte_count %0d, expected %0d", result_o.byte_count,
                                    e.byte_count));
        if (result_o.last_chunk !== e.last_chunk)
          report_mismatch($sformatf("last_chunk %b, expected %b", result_o.last_chunk,
                                    e.last_chunk));
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("Run timed out with %0d chunks outstanding.", expected_chunks.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    in_t it;
    error_count = 0;
    items_sent = 0;
    chunks_seen = 0;
    cycle_count = 0;
    send_idle_pct = 18;
    stimulus_done = 1'b0;
    rst_ni = 1'b0;
    it = plain_item(64'd0, BaseDec);
    it.has_precision = 1'b1;
    pending_items.push_back(it);
    it.alt_prefix = 1'b1;
    it.base_select = BaseHex;
    pending_items.push_back(it);
    it.base_select = BaseOct;
    pending_items.push_back(it);
    pending_items.push_back(plain_item(64'hFFFF_FFFF_FFFF_FFFF, BaseBin));
    pending_items.push_back(plain_item(64'hFFFF_FFFF_FFFF_FFFF, BaseOct));
    pending_items.push_back(plain_item(64'hFFFF_FFFF_FFFF_FFFF, BaseDec));
    it = plain_item(64'hFFFF_FFFF_FFFF_FFFF, BaseHex);
    it.upper_case = 1'b1;
    it.alt_prefix = 1'b1;
    it.group_digits = 1'b1;
    pending_items.push_back(it);
    it.base_select = BaseBin;
    pending_items.push_back(it);
    it = plain_item(64'hDEAD_BEEF_1234_5678, BaseDec);
    it.width_select = Width8;
    it.group_digits = 1'b1;
    it.zero_pad = 1'b1;
    it.min_width = 8'd255;
    pending_items.push_back(it);
    it.width_select = Width16;
    it.min_width = 8'd8;
    pending_items.push_back(it);
    it.base_select = BaseHex;
    it.width_select = Width32;
    it.alt_prefix = 1'b1;
    it.min_width = 8'd12;
    pending_items.push_back(it);
    it.left_align = 1'b1;
    it.min_width = 8'd30;
    pending_items.push_back(it);
    it.left_align = 1'b0;
    it.has_precision = 1'b1;
    it.precision = 7'd127;
    pending_items.push_back(it);
    it.precision = 7'd3;
    it.min_width = 8'd2;
    pending_items.push_back(it);
    it = plain_item(64'd7, BaseBin);
    it.zero_pad = 1'b1;
    it.group_digits = 1'b1;
    it.alt_prefix = 1'b1;
    it.min_width = 8'd13;
    pending_items.push_back(it);
    it.min_width = 8'd1;
    pending_items.push_back(it);
    start = 1'b0;
    item_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int unsigned phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 66 : 0;
      repeat (phase == 0 ? 20 : 32) pending_items.push_back(random_item());
      wait (pending_items.size() == 0 && !start);
    end
    wait (expected_chunks.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("Formatted %0d numbers into %0d chunks over all bases, widths and layouts.",
             items_sent, chunks_seen);
    if (error_count == 0 && expected_chunks.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
